[rtl/psr_pkg.sv]
package psr_pkg;

    // Fixed-point format of the downscale step.
    localparam int STEP_FRAC_BITS = 8;
    localparam int STEP_W         = 16;
    localparam logic [STEP_W-1:0] STEP_ONE        = STEP_W'(1 << STEP_FRAC_BITS);
    localparam logic [STEP_W-1:0] DOWN_STEP_RESET = STEP_W'(256);

    // Widths of the scaler's counters and targets.
    localparam int COL_TGT_W = 28;
    localparam int ROW_TGT_W = 32;
    localparam int OUT_COL_W = 12;
    localparam int ROW_W     = 16;
    localparam int COPY_W    = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_AW    = 3;

    // Command queue between the front and back halves.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Register indexes on the configuration port.
    localparam logic [CFG_AW-1:0] REG_SCALE_MODE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_UP_FACTOR  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_DOWN_STEP  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_IN_WIDTH   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_OUT_WIDTH  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_OUT_HEIGHT = 3'd5;

    localparam logic MODE_UP    = 1'b0;
    localparam logic MODE_DOWN  = 1'b1;
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       last_of_run;
        logic       row_end;
        logic       dropped;
    } out_beat_t;

    typedef struct packed {
        logic              scale_mode;
        logic [3:0]        up_factor;
        logic [STEP_W-1:0] down_step;
        logic [11:0]       in_width;
        logic [11:0]       out_width;
        logic [15:0]       out_height;
    } cfg_t;

    // Control part of one command from the front to the back.
    typedef struct packed {
        logic              wr;       // store the pixel in the line buffer
        logic              rd;       // take the pixel from the line buffer
        logic              row_end;
        logic              dropped;
        logic [COPY_W-1:0] copies;   // number of output beats, at least one
    } cmd_ctrl_t;

endpackage

[rtl/psr_front.sv]
module psr_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_FACTOR = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  psr_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  psr_pkg::in_beat_t   in_data,
    input  logic                q_full,
    output logic                push,
    output psr_pkg::cmd_ctrl_t  cmd_ctrl,
    output psr_pkg::pixel_t     cmd_px,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] cmd_addr
);
    import psr_pkg::*;

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RLW = $clog2(MAX_FACTOR * MAX_WIDTH + 1);
    localparam int CSW = COL_TGT_W + 1;
    localparam int RSW = ROW_TGT_W + 1;

    logic [CW-1:0]        in_col_reg, in_col_next;
    logic [OUT_COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0]     out_row_reg, out_row_next;
    logic [ROW_W-1:0]     in_row_reg, in_row_next;
    logic [COL_TGT_W-1:0] col_target_reg, col_target_next;
    logic [ROW_TGT_W-1:0] row_target_reg, row_target_next;
    logic [RLW-1:0]       replay_left_reg, replay_left_next;
    logic [CW-1:0]        replay_col_reg, replay_col_next;

    logic [WW-1:0]        w;
    logic [COPY_W-1:0]    f;
    logic [STEP_W-1:0]    s;
    logic [OUT_COL_W-1:0] ow;
    logic [ROW_W-1:0]     oh;
    logic [31:0]          iw32;
    logic [31:0]          uf32;
    logic                 accept;
    logic [CW-1:0]        col;
    logic [CW-1:0]        rcol;
    logic                 row_last;
    logic                 rrow_last;
    logic [CSW-1:0]       col_src;
    logic [RSW-1:0]       row_src;
    logic                 row_sel;
    logic                 col_sel;
    logic [WW+3:0]        rl_prod;

    assign in_ready = !q_full && !restart;
    assign accept   = in_valid && in_ready;

    // Effective configuration with out-of-range values clamped.
    always_comb
    begin
        iw32 = 32'(cfg.in_width);
        uf32 = 32'(cfg.up_factor);
        if (iw32 == 32'd0)
            w = WW'(1);
        else if (iw32 > 32'(MAX_WIDTH))
            w = WW'(MAX_WIDTH);
        else
            w = WW'(iw32);
        if (uf32 == 32'd0)
            f = COPY_W'(1);
        else if (uf32 > 32'(MAX_FACTOR))
            f = COPY_W'(MAX_FACTOR);
        else
            f = cfg.up_factor;
        s  = (cfg.down_step < STEP_ONE) ? STEP_ONE : cfg.down_step;
        ow = (cfg.out_width == '0) ? OUT_COL_W'(1) : cfg.out_width;
        oh = (cfg.out_height == '0) ? ROW_W'(1) : cfg.out_height;
    end

    // Column positions and nearest-centre source indexes.
    always_comb
    begin
        col       = (WW'(in_col_reg) < w) ? in_col_reg : '0;
        rcol      = (WW'(replay_col_reg) < w) ? replay_col_reg : '0;
        row_last  = (WW'(col) + WW'(1)) == w;
        rrow_last = (WW'(rcol) + WW'(1)) == w;
        col_src   = (CSW'(col_target_reg) + CSW'(1 << (STEP_FRAC_BITS - 1)))
                    >> STEP_FRAC_BITS;
        row_src   = (RSW'(row_target_reg) + RSW'(1 << (STEP_FRAC_BITS - 1)))
                    >> STEP_FRAC_BITS;
        row_sel   = (out_row_reg < oh) && (RSW'(in_row_reg) == row_src);
        col_sel   = row_sel && (out_col_reg < ow) && (CSW'(col) == col_src);
        rl_prod   = (WW + 4)'(f - COPY_W'(1)) * (WW + 4)'(w);
    end

    always_comb
    begin
        in_col_next      = in_col_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        in_row_next      = in_row_reg;
        col_target_next  = col_target_reg;
        row_target_next  = row_target_reg;
        replay_left_next = replay_left_reg;
        replay_col_next  = replay_col_reg;
        push             = 1'b0;
        cmd_ctrl         = '0;
        cmd_px           = '0;
        cmd_addr         = '0;

        if (restart)
        begin
            in_col_next      = '0;
            out_col_next     = '0;
            out_row_next     = '0;
            in_row_next      = '0;
            replay_left_next = '0;
            replay_col_next  = '0;
            col_target_next  = COL_TGT_W'(cfg.down_step >> 1);
            row_target_next  = ROW_TGT_W'(cfg.down_step >> 1);
        end
        else if (accept)
        begin
            case (cfg.scale_mode)
                MODE_UP:
                begin
                    if (in_data.kind == KIND_TICK)
                    begin
                        if (replay_left_reg != '0)
                        begin
                            push             = 1'b1;
                            cmd_ctrl.rd      = 1'b1;
                            cmd_ctrl.copies  = f;
                            cmd_ctrl.row_end = rrow_last;
                            cmd_addr         = rcol;
                            replay_col_next  = rrow_last ? '0 : rcol + CW'(1);
                            replay_left_next = replay_left_reg - RLW'(1);
                        end
                    end
                    else if (replay_left_reg != '0)
                    begin
                        push             = 1'b1;
                        cmd_ctrl.dropped = 1'b1;
                        cmd_ctrl.copies  = COPY_W'(1);
                    end
                    else
                    begin
                        push             = 1'b1;
                        cmd_ctrl.wr      = 1'b1;
                        cmd_ctrl.copies  = f;
                        cmd_ctrl.row_end = row_last;
                        cmd_addr         = col;
                        cmd_px           = '{red: in_data.red, green: in_data.green,
                                             blue: in_data.blue};
                        if (row_last)
                        begin
                            in_col_next      = '0;
                            replay_col_next  = '0;
                            replay_left_next = RLW'(rl_prod);
                        end
                        else
                        begin
                            in_col_next = col + CW'(1);
                        end
                    end
                end
                MODE_DOWN:
                begin
                    if (in_data.kind == KIND_PIXEL)
                    begin
                        if (col_sel)
                        begin
                            push             = 1'b1;
                            cmd_ctrl.copies  = COPY_W'(1);
                            cmd_ctrl.row_end = ((out_col_reg + OUT_COL_W'(1)) == ow)
                                               || row_last;
                            cmd_px           = '{red: in_data.red, green: in_data.green,
                                                 blue: in_data.blue};
                            out_col_next     = out_col_reg + OUT_COL_W'(1);
                            col_target_next  = col_target_reg + COL_TGT_W'(s);
                        end
                        if (row_last)
                        begin
                            in_col_next     = '0;
                            out_col_next    = '0;
                            col_target_next = COL_TGT_W'(s >> 1);
                            if (row_sel)
                            begin
                                out_row_next    = out_row_reg + ROW_W'(1);
                                row_target_next = row_target_reg + ROW_TGT_W'(s);
                            end
                            if (in_row_reg != '1)
                                in_row_next = in_row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            in_col_next = col + CW'(1);
                        end
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg      <= '0;
            out_col_reg     <= '0;
            out_row_reg     <= '0;
            in_row_reg      <= '0;
            col_target_reg  <= COL_TGT_W'(DOWN_STEP_RESET >> 1);
            row_target_reg  <= ROW_TGT_W'(DOWN_STEP_RESET >> 1);
            replay_left_reg <= '0;
            replay_col_reg  <= '0;
        end
        else
        begin
            in_col_reg      <= in_col_next;
            out_col_reg     <= out_col_next;
            out_row_reg     <= out_row_next;
            in_row_reg      <= in_row_next;
            col_target_reg  <= col_target_next;
            row_target_reg  <= row_target_next;
            replay_left_reg <= replay_left_next;
            replay_col_reg  <= replay_col_next;
        end
    end

endmodule

[rtl/psr_queue.sv]
module psr_queue #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);
    import psr_pkg::*;

    logic [WIDTH-1:0]    slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign full  = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("push into a full command queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("pop from an empty command queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("command queue count out of range");

endmodule

[rtl/psr_back.sv]
module psr_back #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  psr_pkg::cmd_ctrl_t   q_ctrl,
    input  psr_pkg::pixel_t      q_px,
    input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] q_addr,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output psr_pkg::out_beat_t   out_data
);
    import psr_pkg::*;

    pixel_t            line_mem [MAX_WIDTH];
    pixel_t            rd_data_reg;
    pixel_t            b_px_reg;
    cmd_ctrl_t         b_ctrl_reg;
    logic              b_valid_reg, b_valid_next;
    logic [COPY_W-1:0] b_left_reg, b_left_next;
    logic              b_last;
    pixel_t            px;

    assign b_last = b_left_reg == COPY_W'(1);
    assign pop    = q_valid && (!b_valid_reg || (out_ready && b_last));

    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_left_next  = b_left_reg;
        if (pop)
        begin
            b_valid_next = 1'b1;
            b_left_next  = q_ctrl.copies;
        end
        else if (b_valid_reg && out_ready)
        begin
            b_valid_next = !b_last;
            b_left_next  = b_left_reg - COPY_W'(1);
        end
    end

    // Line buffer: written by stored pixels, read by replay commands.
    always_ff @(posedge clk)
    begin
        if (pop && q_ctrl.wr)
            line_mem[q_addr] <= q_px;
        if (pop && q_ctrl.rd)
            rd_data_reg <= line_mem[q_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_px_reg   <= q_px;
            b_ctrl_reg <= q_ctrl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_left_reg  <= '0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            b_left_reg  <= b_left_next;
        end
    end

    assign px        = b_ctrl_reg.rd ? rd_data_reg : b_px_reg;
    assign out_valid = b_valid_reg;

    always_comb
    begin
        out_data.out_blue    = px.blue;
        out_data.out_green   = px.green;
        out_data.out_red     = px.red;
        out_data.last_of_run = b_last;
        out_data.row_end     = b_ctrl_reg.row_end && b_last;
        out_data.dropped     = b_ctrl_reg.dropped;
    end

    a_copies_left: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> b_left_reg != '0)
        else $error("output stage holds a command with no beats left");

    a_drop_single: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_ctrl_reg.dropped |-> b_last && !b_ctrl_reg.rd && !b_ctrl_reg.wr)
        else $error("dropped pixel must give exactly one beat");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !out_ready |=> b_valid_reg && $stable(b_left_reg))
        else $error("output stage advanced while stalled");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !(q_ctrl.wr && q_ctrl.rd))
        else $error("command both writes and reads the line buffer");

endmodule

[rtl/pixel_stream_resizer.sv]
// Nearest-neighbor image scaler for a raster stream of BGR pixels. An input
// beat is a pixel or a replay tick; in upscale mode (scale_mode 0) every pixel
// is written to a line buffer and sent up_factor times, and once a row ends the
// row is repeated up_factor - 1 more times, one buffered pixel per tick beat
// (up_factor beats each). A pixel that arrives while replay ticks are still
// owed comes back as a single beat with dropped set and black color. In
// downscale mode (scale_mode 1) a pixel is passed on only where it is the
// nearest-center source of an output pixel under the Q8.8 step down_step,
// clamped to out_width by out_height. A write to any of the six configuration
// registers restarts the row and column counters; the line buffer keeps its
// contents and needs no clearing after reset. Timing: the input side takes one
// beat per cycle while the four-entry command queue has room (no beat is taken
// in the cycle after such a write). The output register sends one beat per
// cycle while out_ready is high, so an upscale pixel or tick gives up_factor
// beats (1 to 8) and a downscale pixel at most one; the output copy counter
// sets the sustained rate.
module pixel_stream_resizer #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_FACTOR = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [psr_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [psr_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  psr_pkg::in_beat_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output psr_pkg::out_beat_t                 out_data
);
    import psr_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int QW = CW + $bits(cmd_ctrl_t) + $bits(pixel_t);

    // Configuration registers and the restart pulse that follows a write.
    cfg_t cfg_reg, cfg_next;
    logic restart_reg, restart_next;

    always_comb
    begin
        cfg_next     = cfg_reg;
        restart_next = 1'b0;
        if (cfg_we)
        begin
            restart_next = 1'b1;
            case (cfg_addr)
                REG_SCALE_MODE: cfg_next.scale_mode = cfg_wdata[0];
                REG_UP_FACTOR:  cfg_next.up_factor  = cfg_wdata[3:0];
                REG_DOWN_STEP:  cfg_next.down_step  = cfg_wdata;
                REG_IN_WIDTH:   cfg_next.in_width   = cfg_wdata[11:0];
                REG_OUT_WIDTH:  cfg_next.out_width  = cfg_wdata[11:0];
                REG_OUT_HEIGHT: cfg_next.out_height = cfg_wdata;
                default:        restart_next        = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_mode <= MODE_UP;
            cfg_reg.up_factor  <= 4'd1;
            cfg_reg.down_step  <= DOWN_STEP_RESET;
            cfg_reg.in_width   <= 12'd1;
            cfg_reg.out_width  <= 12'd1;
            cfg_reg.out_height <= 16'd1;
            restart_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            restart_reg <= restart_next;
        end
    end

    // Front half: classifies each beat and keeps the row and column state.
    logic            push;
    logic            q_full;
    cmd_ctrl_t       f_ctrl;
    pixel_t          f_px;
    logic [CW-1:0]   f_addr;

    psr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart_reg),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .cmd_ctrl (f_ctrl),
        .cmd_px   (f_px),
        .cmd_addr (f_addr)
    );

    // Command queue that lets the input side run ahead of the copy loop.
    logic            q_valid;
    logic            pop;
    logic [QW-1:0]   q_rdata;
    cmd_ctrl_t       b_ctrl;
    pixel_t          b_px;
    logic [CW-1:0]   b_addr;

    psr_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({f_addr, f_ctrl, f_px}),
        .full  (q_full),
        .pop   (pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    assign {b_addr, b_ctrl, b_px} = q_rdata;

    // Back half: line buffer access and one output beat per cycle while out_ready is high.
    psr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ctrl    (b_ctrl),
        .q_px      (b_px),
        .q_addr    (b_addr),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
